@@ hdl/afp_pkg.sv @@
// ---------------------------------------------------------------------------
// afp_pkg: shared types and constants of the rectangle placer
// Register indexes, mode and alignment codes, default field widths and the
// flag group that travels down the pipeline.
// ---------------------------------------------------------------------------
package afp_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_FIT_MODE   = 2'd0,
      REG_SIZE_LIMIT = 2'd1,
      REG_X_ALIGN    = 2'd2,
      REG_Y_ALIGN    = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      FIT_MIN     = 2'd0,
      FIT_FILL    = 2'd1,
      FIT_STRETCH = 2'd2
   } fit_mode_type;

   typedef enum logic [1:0] {
      ALIGN_START  = 2'd0,
      ALIGN_END    = 2'd1,
      ALIGN_CENTRE = 2'd2
   } align_type;

   localparam int LIMIT_MAX_ONE = 0;
   localparam int LIMIT_MIN_ONE = 1;

   typedef struct packed {
      logic skip;
      logic sat;
   } flags_type;

endpackage

@@ hdl/afp_div_cell.sv @@
// ---------------------------------------------------------------------------
// afp_div_cell: one quotient bit of the two scale dividers
// Restoring step for both axes; hands remainder, quotient and the word's
// fields to the next cell.
// ---------------------------------------------------------------------------
module afp_div_cell #(
   parameter int COORD_BITS = afp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = afp_pkg::FRAC_BITS_DEF,
   parameter int IDX        = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [8*COORD_BITS-1:0]          in_side,
   input  logic [COORD_BITS-1:0]            in_rem_x,
   input  logic [COORD_BITS-1:0]            in_rem_y,
   input  logic [COORD_BITS+FRAC_BITS-1:0]  in_qx,
   input  logic [COORD_BITS+FRAC_BITS-1:0]  in_qy,
   output logic                             out_valid,
   output logic [8*COORD_BITS-1:0]          out_side,
   output logic [COORD_BITS-1:0]            out_rem_x,
   output logic [COORD_BITS-1:0]            out_rem_y,
   output logic [COORD_BITS+FRAC_BITS-1:0]  out_qx,
   output logic [COORD_BITS+FRAC_BITS-1:0]  out_qy
);

   localparam int W  = COORD_BITS;
   localparam int QW = COORD_BITS + FRAC_BITS;
   localparam int QB = QW - 1 - IDX;

   logic [W-1:0]  src_w, src_h, dst_w, dst_h;
   logic          bit_x, bit_y;
   logic [W:0]    trial_x, trial_y, diff_x, diff_y;
   logic          ge_x, ge_y;

   logic          valid_ff;
   logic [8*W-1:0] side_ff;
   logic [W-1:0]  rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [QW-1:0] qx_ff, qx_in, qy_ff, qy_in;

   assign src_w = in_side[2*W +: W];
   assign src_h = in_side[3*W +: W];
   assign dst_w = in_side[6*W +: W];
   assign dst_h = in_side[7*W +: W];

   if (IDX < W) begin : g_num
      assign bit_x = dst_w[W-1-IDX];
      assign bit_y = dst_h[W-1-IDX];
   end else begin : g_zero
      assign bit_x = 1'b0;
      assign bit_y = 1'b0;
   end

   always_comb begin
      trial_x = {in_rem_x, bit_x};
      trial_y = {in_rem_y, bit_y};
      diff_x  = trial_x - {1'b0, src_w};
      diff_y  = trial_y - {1'b0, src_h};
      ge_x    = trial_x >= {1'b0, src_w};
      ge_y    = trial_y >= {1'b0, src_h};
      rem_x_in = ge_x ? diff_x[W-1:0] : trial_x[W-1:0];
      rem_y_in = ge_y ? diff_y[W-1:0] : trial_y[W-1:0];
      qx_in = in_qx;
      qy_in = in_qy;
      qx_in[QB] = ge_x;
      qy_in[QB] = ge_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff  <= in_side;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         qx_ff    <= qx_in;
         qy_ff    <= qy_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem_x = rem_x_ff;
   assign out_rem_y = rem_y_ff;
   assign out_qx    = qx_ff;
   assign out_qy    = qy_ff;

endmodule

@@ hdl/afp_scale.sv @@
// ---------------------------------------------------------------------------
// afp_scale: scale choice and size multiply
// Pick and clamp the scale, form partial products, then sum and saturate
// the placed width and height. Three register stages.
// ---------------------------------------------------------------------------
module afp_scale #(
   parameter int COORD_BITS = afp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = afp_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  afp_pkg::fit_mode_type            fit_mode,
   input  logic [1:0]                       size_limit,
   input  logic                             in_valid,
   input  logic [8*COORD_BITS-1:0]          in_side,
   input  logic [COORD_BITS+FRAC_BITS-1:0]  in_qx,
   input  logic [COORD_BITS+FRAC_BITS-1:0]  in_qy,
   output logic                             out_valid,
   output logic [8*COORD_BITS-1:0]          out_side,
   output afp_pkg::flags_type               out_flags,
   output logic [COORD_BITS-1:0]            out_w,
   output logic [COORD_BITS-1:0]            out_h
);

   localparam int W  = COORD_BITS;
   localparam int QW = COORD_BITS + FRAC_BITS;
   localparam int SW = (QW > 64) ? 64 : QW;
   localparam int HW = SW - W;
   localparam int PW = W + SW;
   localparam logic [SW-1:0] ONE = SW'(1) << FRAC_BITS;

   logic [SW-1:0] qx_s, qy_s, scale_in;
   logic          cx, cy, clip_in, pick_x;
   logic [W-1:0]  src_w_a, src_h_a;
   logic [PW-1:0] prod_w, prod_h;
   logic          over_w, over_h;

   logic [2:0]    valid_ff;
   logic [8*W-1:0] side_a_ff, side_b_ff, side_c_ff;
   afp_pkg::flags_type flags_a_ff, flags_a_in, flags_b_ff, flags_c_ff, flags_c_in;
   logic [SW-1:0] scale_ff;
   logic [2*W-1:0] lo_w_ff, lo_w_in, lo_h_ff, lo_h_in;
   logic [SW-1:0] hi_w_ff, hi_w_in, hi_h_ff, hi_h_in;
   logic [W-1:0]  w_ff, w_in, h_ff, h_in;

   if (QW > 64) begin : g_clip
      assign cx   = |in_qx[QW-1:SW];
      assign cy   = |in_qy[QW-1:SW];
      assign qx_s = cx ? '1 : in_qx[SW-1:0];
      assign qy_s = cy ? '1 : in_qy[SW-1:0];
   end else begin : g_full
      assign cx   = 1'b0;
      assign cy   = 1'b0;
      assign qx_s = in_qx[SW-1:0];
      assign qy_s = in_qy[SW-1:0];
   end

   always_comb begin
      pick_x   = (qx_s < qy_s) == (fit_mode == afp_pkg::FIT_MIN);
      scale_in = pick_x ? qx_s : qy_s;
      clip_in  = pick_x ? cx : cy;
      if (qx_s == qy_s) begin
         scale_in = qx_s;
         clip_in  = cx & cy;
      end
      if (size_limit[afp_pkg::LIMIT_MAX_ONE] && scale_in > ONE) begin
         scale_in = ONE;
         clip_in  = 1'b0;
      end
      if (size_limit[afp_pkg::LIMIT_MIN_ONE] && scale_in < ONE) begin
         scale_in = ONE;
      end
      flags_a_in.skip = (in_side[2*W +: W] == '0) || (in_side[3*W +: W] == '0);
      flags_a_in.sat  = clip_in;
   end

   assign src_w_a = side_a_ff[2*W +: W];
   assign src_h_a = side_a_ff[3*W +: W];
   assign lo_w_in = {{W{1'b0}}, src_w_a} * {{W{1'b0}}, scale_ff[W-1:0]};
   assign lo_h_in = {{W{1'b0}}, src_h_a} * {{W{1'b0}}, scale_ff[W-1:0]};
   assign hi_w_in = SW'(src_w_a) * SW'(scale_ff[SW-1:W]);
   assign hi_h_in = SW'(src_h_a) * SW'(scale_ff[SW-1:W]);

   always_comb begin
      prod_w = {{HW{1'b0}}, lo_w_ff} + {hi_w_ff, {W{1'b0}}};
      prod_h = {{HW{1'b0}}, lo_h_ff} + {hi_h_ff, {W{1'b0}}};
      over_w = |prod_w[PW-1:W+FRAC_BITS];
      over_h = |prod_h[PW-1:W+FRAC_BITS];
      w_in   = over_w ? '1 : prod_w[W+FRAC_BITS-1:FRAC_BITS];
      h_in   = over_h ? '1 : prod_h[W+FRAC_BITS-1:FRAC_BITS];
      flags_c_in.skip = flags_b_ff.skip;
      flags_c_in.sat  = flags_b_ff.sat | over_w | over_h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_a_ff  <= in_side;
         flags_a_ff <= flags_a_in;
         scale_ff   <= scale_in;
         side_b_ff  <= side_a_ff;
         flags_b_ff <= flags_a_ff;
         lo_w_ff    <= lo_w_in;
         lo_h_ff    <= lo_h_in;
         hi_w_ff    <= hi_w_in;
         hi_h_ff    <= hi_h_in;
         side_c_ff  <= side_b_ff;
         flags_c_ff <= flags_c_in;
         w_ff       <= w_in;
         h_ff       <= h_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_side  = side_c_ff;
   assign out_flags = flags_c_ff;
   assign out_w     = w_ff;
   assign out_h     = h_ff;

endmodule

@@ hdl/afp_place.sv @@
// ---------------------------------------------------------------------------
// afp_place: alignment and output register
// Place each axis in the destination, saturate, and select the pass-through
// cases for a zero source or stretch mode.
// ---------------------------------------------------------------------------
module afp_place #(
   parameter int COORD_BITS = afp_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         stretch,
   input  afp_pkg::align_type           x_align,
   input  afp_pkg::align_type           y_align,
   input  logic                         in_valid,
   input  logic [8*COORD_BITS-1:0]      in_side,
   input  afp_pkg::flags_type           in_flags,
   input  logic [COORD_BITS-1:0]        in_w,
   input  logic [COORD_BITS-1:0]        in_h,
   output logic                         out_valid,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic [COORD_BITS-1:0]        out_w,
   output logic [COORD_BITS-1:0]        out_h,
   output logic                         out_skipped,
   output logic                         out_saturated
);

   localparam int W = COORD_BITS;

   logic signed [W:0]   diff_x, diff_y;
   logic signed [W+1:0] off_x, off_y, pos_x, pos_y;
   logic                sat_x, sat_y;
   logic [W-1:0]        px, py;

   logic         valid_ff;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic         skip_ff, skip_in, sat_ff, sat_in;

   always_comb begin
      diff_x = $signed({1'b0, in_side[6*W +: W]}) - $signed({1'b0, in_w});
      diff_y = $signed({1'b0, in_side[7*W +: W]}) - $signed({1'b0, in_h});
      case (x_align)
         afp_pkg::ALIGN_START: off_x = '0;
         afp_pkg::ALIGN_END:   off_x = (W+2)'(diff_x);
         default:              off_x = (W+2)'(diff_x >>> 1);
      endcase
      case (y_align)
         afp_pkg::ALIGN_START: off_y = '0;
         afp_pkg::ALIGN_END:   off_y = (W+2)'(diff_y);
         default:              off_y = (W+2)'(diff_y >>> 1);
      endcase
      pos_x = (W+2)'($signed(in_side[4*W +: W])) + off_x;
      pos_y = (W+2)'($signed(in_side[5*W +: W])) + off_y;
      sat_x = (pos_x[W+1:W-1] != '0) && (pos_x[W+1:W-1] != '1);
      sat_y = (pos_y[W+1:W-1] != '0) && (pos_y[W+1:W-1] != '1);
      px = sat_x ? {pos_x[W+1], {(W-1){~pos_x[W+1]}}} : pos_x[W-1:0];
      py = sat_y ? {pos_y[W+1], {(W-1){~pos_y[W+1]}}} : pos_y[W-1:0];

      if (in_flags.skip) begin
         x_in = in_side[0*W +: W];
         y_in = in_side[1*W +: W];
         w_in = in_side[2*W +: W];
         h_in = in_side[3*W +: W];
         skip_in = 1'b1;
         sat_in  = 1'b0;
      end else if (stretch) begin
         x_in = in_side[4*W +: W];
         y_in = in_side[5*W +: W];
         w_in = in_side[6*W +: W];
         h_in = in_side[7*W +: W];
         skip_in = 1'b0;
         sat_in  = 1'b0;
      end else begin
         x_in = px;
         y_in = py;
         w_in = in_w;
         h_in = in_h;
         skip_in = 1'b0;
         sat_in  = in_flags.sat | sat_x | sat_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         w_ff    <= w_in;
         h_ff    <= h_in;
         skip_ff <= skip_in;
         sat_ff  <= sat_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_x         = $signed(x_ff);
   assign out_y         = $signed(y_ff);
   assign out_w         = w_ff;
   assign out_h         = h_ff;
   assign out_skipped   = skip_ff;
   assign out_saturated = sat_ff;

endmodule

@@ hdl/aspect_fit_rectangle_placer.sv @@
// ---------------------------------------------------------------------------
// aspect_fit_rectangle_placer: fit, fill or stretch a rectangle into another
// Request word: source and destination rectangles in integer coordinates.
// Response word: placed rectangle with skipped and saturated flags.
// Both channels are valid/ready; the csr_ port writes the four mode
// registers (fit mode, size limit, x and y alignment) and has no read-back.
// The two scale quotients come from a row of COORD_BITS+FRAC_BITS divider
// cells, one quotient bit per cell, followed by three stages for the scale
// choice and size multiply and one output stage for alignment.
// Throughput: one word per cycle unless a stalled response holds the
// pipeline; the divider row is fully pipelined.
// A stalled response freezes the whole pipeline; req_ready falls in the same
// cycle and a waiting response holds until taken. A word is accepted while
// the response register is being emptied.
// Reset empties the pipeline, holds req_ready low and sets fit mode 0,
// size limit 0 and both alignments to centre.
// ---------------------------------------------------------------------------
module aspect_fit_rectangle_placer #(
   parameter int COORD_BITS = afp_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = afp_pkg::FRAC_BITS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [afp_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [afp_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [COORD_BITS-1:0]            req_src_x,
   input  logic signed [COORD_BITS-1:0]            req_src_y,
   input  logic [COORD_BITS-1:0]                   req_src_w,
   input  logic [COORD_BITS-1:0]                   req_src_h,
   input  logic signed [COORD_BITS-1:0]            req_dst_x,
   input  logic signed [COORD_BITS-1:0]            req_dst_y,
   input  logic [COORD_BITS-1:0]                   req_dst_w,
   input  logic [COORD_BITS-1:0]                   req_dst_h,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [COORD_BITS-1:0]            rsp_out_x,
   output logic signed [COORD_BITS-1:0]            rsp_out_y,
   output logic [COORD_BITS-1:0]                   rsp_out_w,
   output logic [COORD_BITS-1:0]                   rsp_out_h,
   output logic                                    rsp_skipped,
   output logic                                    rsp_saturated
);

   localparam int W  = COORD_BITS;
   localparam int QW = COORD_BITS + FRAC_BITS;

   afp_pkg::fit_mode_type fit_mode_ff;
   logic [1:0]            size_limit_ff;
   afp_pkg::align_type    x_align_ff, y_align_ff;

   logic en;

   logic            c_valid [0:QW];
   logic [8*W-1:0]  c_side  [0:QW];
   logic [W-1:0]    c_rem_x [0:QW];
   logic [W-1:0]    c_rem_y [0:QW];
   logic [QW-1:0]   c_qx    [0:QW];
   logic [QW-1:0]   c_qy    [0:QW];

   logic               s_valid;
   logic [8*W-1:0]     s_side;
   afp_pkg::flags_type s_flags;
   logic [W-1:0]       s_w, s_h;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= afp_pkg::FIT_MIN;
         size_limit_ff <= 2'd0;
         x_align_ff    <= afp_pkg::ALIGN_CENTRE;
         y_align_ff    <= afp_pkg::ALIGN_CENTRE;
      end else if (csr_we) begin
         case (afp_pkg::reg_index_type'(csr_index))
            afp_pkg::REG_FIT_MODE:   fit_mode_ff   <= afp_pkg::fit_mode_type'(csr_wdata);
            afp_pkg::REG_SIZE_LIMIT: size_limit_ff <= csr_wdata;
            afp_pkg::REG_X_ALIGN:    x_align_ff    <= afp_pkg::align_type'(csr_wdata);
            afp_pkg::REG_Y_ALIGN:    y_align_ff    <= afp_pkg::align_type'(csr_wdata);
            default: ;
         endcase
      end
   end

   assign en        = ~rsp_valid | rsp_ready;
   assign req_ready = en & ~reset;

   assign c_valid[0] = req_valid;
   assign c_side[0]  = {req_dst_h, req_dst_w, req_dst_y, req_dst_x,
                        req_src_h, req_src_w, req_src_y, req_src_x};
   assign c_rem_x[0] = '0;
   assign c_rem_y[0] = '0;
   assign c_qx[0]    = '0;
   assign c_qy[0]    = '0;

   for (genvar i = 0; i < QW; i++) begin : g_cell
      afp_div_cell #(
         .COORD_BITS (COORD_BITS),
         .FRAC_BITS  (FRAC_BITS),
         .IDX        (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (c_valid[i]),
         .in_side   (c_side[i]),
         .in_rem_x  (c_rem_x[i]),
         .in_rem_y  (c_rem_y[i]),
         .in_qx     (c_qx[i]),
         .in_qy     (c_qy[i]),
         .out_valid (c_valid[i+1]),
         .out_side  (c_side[i+1]),
         .out_rem_x (c_rem_x[i+1]),
         .out_rem_y (c_rem_y[i+1]),
         .out_qx    (c_qx[i+1]),
         .out_qy    (c_qy[i+1])
      );
   end

   afp_scale #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .fit_mode   (fit_mode_ff),
      .size_limit (size_limit_ff),
      .in_valid   (c_valid[QW]),
      .in_side    (c_side[QW]),
      .in_qx      (c_qx[QW]),
      .in_qy      (c_qy[QW]),
      .out_valid  (s_valid),
      .out_side   (s_side),
      .out_flags  (s_flags),
      .out_w      (s_w),
      .out_h      (s_h)
   );

   afp_place #(
      .COORD_BITS (COORD_BITS)
   ) u_place (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .stretch       (fit_mode_ff[1]),
      .x_align       (x_align_ff),
      .y_align       (y_align_ff),
      .in_valid      (s_valid),
      .in_side       (s_side),
      .in_flags      (s_flags),
      .in_w          (s_w),
      .in_h          (s_h),
      .out_valid     (rsp_valid),
      .out_x         (rsp_out_x),
      .out_y         (rsp_out_y),
      .out_w         (rsp_out_w),
      .out_h         (rsp_out_h),
      .out_skipped   (rsp_skipped),
      .out_saturated (rsp_saturated)
   );

endmodule
